@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
// clocked on clk and switched off while rst is high; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

@@ rtl/pdtq_pkg.sv @@
// shared codes and types of the ready and delay task queues
// operation, status and micro-op codes, controller/datapath structs; no dependencies
package pdtq_pkg;

  // remaining tick count of a waiting task (delay plus one)
  localparam int TICK_W = 9;

  // operation codes
  localparam logic [1:0] OP_ENQUEUE  = 2'd0;
  localparam logic [1:0] OP_RERUN    = 2'd1;
  localparam logic [1:0] OP_DISPATCH = 2'd2;
  localparam logic [1:0] OP_TICK     = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_READY_FULL = 2'd1;
  localparam logic [1:0] ST_WAIT_FULL  = 2'd2;
  localparam logic [1:0] ST_NO_TASK    = 2'd3;

  // datapath micro-ops
  localparam logic [3:0] UOP_NOP         = 4'd0;
  localparam logic [3:0] UOP_LOAD        = 4'd1;
  localparam logic [3:0] UOP_RI_START    = 4'd2;
  localparam logic [3:0] UOP_RI_SCAN     = 4'd3;
  localparam logic [3:0] UOP_RI_PLACE    = 4'd4;
  localparam logic [3:0] UOP_WI_START    = 4'd5;
  localparam logic [3:0] UOP_WI_SCAN     = 4'd6;
  localparam logic [3:0] UOP_WI_PLACE    = 4'd7;
  localparam logic [3:0] UOP_DISP_READ   = 4'd8;
  localparam logic [3:0] UOP_DISP_TAKE   = 4'd9;
  localparam logic [3:0] UOP_T_START     = 4'd10;
  localparam logic [3:0] UOP_T_SWEEP     = 4'd11;
  localparam logic [3:0] UOP_W_READ_HEAD = 4'd12;
  localparam logic [3:0] UOP_CAND_WAIT   = 4'd13;
  localparam logic [3:0] UOP_W_POP       = 4'd14;

  typedef struct packed {
    logic [3:0] uop;
    logic       res_load;
  } cmd_t;

  typedef struct packed {
    logic last_valid;
    logic rfull;
    logic rempty;
    logic wfull;
    logic wempty;
    logic r_shift;
    logic w_shift;
    logic k_one;
    logic k_last;
    logic w_head_zero;
  } stat_t;

  typedef struct packed {
    logic       found;
    logic [7:0] task_id;
    logic [7:0] prio;
    logic [1:0] status;
    logic [4:0] ready_entries;
    logic [4:0] waiting_entries;
  } res_t;

endpackage

@@ rtl/pdtq_ctrl.sv @@
// controller state machine of the ready and delay task queues
// sequences datapath micro-ops; depends on pdtq_pkg
module pdtq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      operation,
  input  logic [7:0]      delay,
  input  logic            out_free,
  input  pdtq_pkg::stat_t stat,
  output pdtq_pkg::cmd_t  cmd,
  output logic            busy
);
  import pdtq_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_RI_START  = 4'd1;
  localparam logic [3:0] S_RI_SCAN   = 4'd2;
  localparam logic [3:0] S_RI_PLACE  = 4'd3;
  localparam logic [3:0] S_WI_START  = 4'd4;
  localparam logic [3:0] S_WI_SCAN   = 4'd5;
  localparam logic [3:0] S_WI_PLACE  = 4'd6;
  localparam logic [3:0] S_DISP_READ = 4'd7;
  localparam logic [3:0] S_DISP_TAKE = 4'd8;
  localparam logic [3:0] S_T_START   = 4'd9;
  localparam logic [3:0] S_T_SWEEP   = 4'd10;
  localparam logic [3:0] S_T_HEAD    = 4'd11;
  localparam logic [3:0] S_T_CHECK   = 4'd12;
  localparam logic [3:0] S_T_POP     = 4'd13;
  localparam logic [3:0] S_FIN       = 4'd14;

  logic [3:0] state, state_next;
  logic       tick_ctx, tick_ctx_next;
  logic [3:0] ri_done;

  // a ready insert returns to the tick loop or finishes the word
  assign ri_done = tick_ctx ? S_T_POP : S_FIN;
  assign busy    = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tick_ctx <= 1'b0;
    end else begin
      state    <= state_next;
      tick_ctx <= tick_ctx_next;
    end
  end

  // next state and micro-op
  always_comb begin
    state_next    = state;
    tick_ctx_next = tick_ctx;
    cmd.uop       = UOP_NOP;
    cmd.res_load  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.uop       = UOP_LOAD;
          tick_ctx_next = (operation == OP_TICK);
          case (operation)
            OP_ENQUEUE:  state_next = S_RI_START;
            OP_RERUN: begin
              if (!stat.last_valid) state_next = S_FIN;
              else if (delay == 8'd0) state_next = S_RI_START;
              else state_next = S_WI_START;
            end
            OP_DISPATCH: state_next = S_DISP_READ;
            default:     state_next = S_T_START;
          endcase
        end
      end
      S_RI_START: begin
        cmd.uop = UOP_RI_START;
        if (stat.rfull) state_next = S_FIN;
        else if (stat.rempty) state_next = S_RI_PLACE;
        else state_next = S_RI_SCAN;
      end
      S_RI_SCAN: begin
        cmd.uop = UOP_RI_SCAN;
        if (!stat.r_shift) state_next = ri_done;
        else if (stat.k_one) state_next = S_RI_PLACE;
      end
      S_RI_PLACE: begin
        cmd.uop    = UOP_RI_PLACE;
        state_next = ri_done;
      end
      S_WI_START: begin
        cmd.uop = UOP_WI_START;
        if (stat.wfull) state_next = S_FIN;
        else if (stat.wempty) state_next = S_WI_PLACE;
        else state_next = S_WI_SCAN;
      end
      S_WI_SCAN: begin
        cmd.uop = UOP_WI_SCAN;
        if (!stat.w_shift) state_next = S_FIN;
        else if (stat.k_one) state_next = S_WI_PLACE;
      end
      S_WI_PLACE: begin
        cmd.uop    = UOP_WI_PLACE;
        state_next = S_FIN;
      end
      S_DISP_READ: begin
        cmd.uop    = UOP_DISP_READ;
        state_next = stat.rempty ? S_FIN : S_DISP_TAKE;
      end
      S_DISP_TAKE: begin
        cmd.uop    = UOP_DISP_TAKE;
        state_next = S_FIN;
      end
      S_T_START: begin
        cmd.uop    = UOP_T_START;
        state_next = stat.wempty ? S_FIN : S_T_SWEEP;
      end
      S_T_SWEEP: begin
        cmd.uop = UOP_T_SWEEP;
        if (stat.k_last) state_next = S_T_HEAD;
      end
      S_T_HEAD: begin
        cmd.uop    = UOP_W_READ_HEAD;
        state_next = stat.wempty ? S_FIN : S_T_CHECK;
      end
      S_T_CHECK: begin
        cmd.uop    = UOP_CAND_WAIT;
        state_next = stat.w_head_zero ? S_RI_START : S_FIN;
      end
      S_T_POP: begin
        cmd.uop    = UOP_W_POP;
        state_next = S_T_HEAD;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/pdtq_dp.sv @@
// datapath of the ready and delay task queues
// circular sorted queues in memories, scan index, last task and result; depends on pdtq_pkg
module pdtq_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  pdtq_pkg::cmd_t  cmd,
  input  logic [1:0]      operation,
  input  logic [7:0]      task_id,
  input  logic [7:0]      priority_req,
  input  logic [7:0]      delay,
  output pdtq_pkg::stat_t stat,
  output pdtq_pkg::res_t  res
);
  import pdtq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(QUEUE_DEPTH);

  // logical queue position to memory address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] idx);
    logic [CW:0] sum;
    sum = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, idx};
    if (sum >= DEPTH_W) sum = sum - DEPTH_W;
    return sum[AW-1:0];
  endfunction

  // queue memories
  logic [ID_BITS-1:0] r_id_mem   [QUEUE_DEPTH];
  logic [7:0]         r_prio_mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0] w_id_mem   [QUEUE_DEPTH];
  logic [7:0]         w_prio_mem [QUEUE_DEPTH];
  logic [TICK_W-1:0]  w_tick_mem [QUEUE_DEPTH];

  logic [ID_BITS-1:0] rrd_id, wrd_id;
  logic [7:0]         rrd_prio, wrd_prio;
  logic [TICK_W-1:0]  wrd_tick;

  // queue pointers, scan index, candidate, last task, result
  logic [AW-1:0]      rhead, whead;
  logic [CW-1:0]      rcount, wcount, k;
  logic [ID_BITS-1:0] cand_id, last_id, res_id;
  logic [7:0]         cand_prio, last_prio, res_prio;
  logic [TICK_W-1:0]  new_ticks;
  logic               last_valid, res_found;
  logic [1:0]         res_status;

  // memory port controls
  logic               r_rd_en, r_wr_en, w_rd_en, w_wr_en;
  logic [CW-1:0]      r_rd_idx, r_wr_idx, w_rd_idx, w_wr_idx;
  logic [AW-1:0]      r_rd_addr, r_wr_addr, w_rd_addr, w_wr_addr;
  logic [ID_BITS-1:0] r_wr_id, w_wr_id;
  logic [7:0]         r_wr_prio, w_wr_prio;
  logic [TICK_W-1:0]  w_wr_tick, tick_dec;

  logic [ID_BITS+7:0] in_id_ext;
  logic [ID_BITS-1:0] in_id;
  logic [ID_BITS+7:0] out_id_ext;
  logic [CW+4:0]      r_cnt_ext, w_cnt_ext;

  assign in_id_ext  = {{ID_BITS{1'b0}}, task_id};
  assign in_id      = in_id_ext[ID_BITS-1:0];
  assign out_id_ext = {8'd0, res_id};
  assign r_cnt_ext  = {5'd0, rcount};
  assign w_cnt_ext  = {5'd0, wcount};
  assign tick_dec   = (wrd_tick == '0) ? wrd_tick : wrd_tick - TICK_W'(1);

  // status towards the controller
  assign stat.last_valid  = last_valid;
  assign stat.rfull       = (rcount == CW'(QUEUE_DEPTH));
  assign stat.rempty      = (rcount == '0);
  assign stat.wfull       = (wcount == CW'(QUEUE_DEPTH));
  assign stat.wempty      = (wcount == '0);
  assign stat.r_shift     = (rrd_prio < cand_prio);
  assign stat.w_shift     = (wrd_tick > new_ticks);
  assign stat.k_one       = (k == CW'(1));
  assign stat.k_last      = ((k + CW'(1)) == wcount);
  assign stat.w_head_zero = (wrd_tick == '0);

  // result word
  assign res.found           = res_found;
  assign res.task_id         = out_id_ext[7:0];
  assign res.prio            = res_prio;
  assign res.status          = res_status;
  assign res.ready_entries   = r_cnt_ext[4:0];
  assign res.waiting_entries = w_cnt_ext[4:0];

  assign r_rd_addr = phys(rhead, r_rd_idx);
  assign r_wr_addr = phys(rhead, r_wr_idx);
  assign w_rd_addr = phys(whead, w_rd_idx);
  assign w_wr_addr = phys(whead, w_wr_idx);

  // memory port selection per micro-op
  always_comb begin
    r_rd_en   = 1'b0;
    r_rd_idx  = '0;
    r_wr_en   = 1'b0;
    r_wr_idx  = k;
    r_wr_id   = cand_id;
    r_wr_prio = cand_prio;
    w_rd_en   = 1'b0;
    w_rd_idx  = '0;
    w_wr_en   = 1'b0;
    w_wr_idx  = k;
    w_wr_id   = cand_id;
    w_wr_prio = cand_prio;
    w_wr_tick = new_ticks;
    case (cmd.uop)
      UOP_RI_START: begin
        r_rd_en  = 1'b1;
        r_rd_idx = rcount - CW'(1);
      end
      UOP_RI_SCAN: begin
        r_wr_en = 1'b1;
        if (stat.r_shift) begin
          r_wr_id   = rrd_id;
          r_wr_prio = rrd_prio;
          r_rd_en   = 1'b1;
          r_rd_idx  = k - CW'(2);
        end
      end
      UOP_RI_PLACE: r_wr_en = 1'b1;
      UOP_WI_START: begin
        w_rd_en  = 1'b1;
        w_rd_idx = wcount - CW'(1);
      end
      UOP_WI_SCAN: begin
        w_wr_en = 1'b1;
        if (stat.w_shift) begin
          w_wr_id   = wrd_id;
          w_wr_prio = wrd_prio;
          w_wr_tick = wrd_tick;
          w_rd_en   = 1'b1;
          w_rd_idx  = k - CW'(2);
        end
      end
      UOP_WI_PLACE: w_wr_en = 1'b1;
      UOP_DISP_READ: r_rd_en = 1'b1;
      UOP_T_START: w_rd_en = 1'b1;
      UOP_T_SWEEP: begin
        w_wr_en   = 1'b1;
        w_wr_id   = wrd_id;
        w_wr_prio = wrd_prio;
        w_wr_tick = tick_dec;
        w_rd_en   = 1'b1;
        w_rd_idx  = k + CW'(1);
      end
      UOP_W_READ_HEAD: w_rd_en = 1'b1;
      default: ;
    endcase
  end

  // ready queue memory
  always_ff @(posedge clk) begin
    if (r_wr_en) begin
      r_id_mem[r_wr_addr]   <= r_wr_id;
      r_prio_mem[r_wr_addr] <= r_wr_prio;
    end
    if (r_rd_en) begin
      rrd_id   <= r_id_mem[r_rd_addr];
      rrd_prio <= r_prio_mem[r_rd_addr];
    end
  end

  // delay queue memory
  always_ff @(posedge clk) begin
    if (w_wr_en) begin
      w_id_mem[w_wr_addr]   <= w_wr_id;
      w_prio_mem[w_wr_addr] <= w_wr_prio;
      w_tick_mem[w_wr_addr] <= w_wr_tick;
    end
    if (w_rd_en) begin
      wrd_id   <= w_id_mem[w_rd_addr];
      wrd_prio <= w_prio_mem[w_rd_addr];
      wrd_tick <= w_tick_mem[w_rd_addr];
    end
  end

  // pointers, counts, candidate and result
  always_ff @(posedge clk) begin
    if (rst) begin
      rhead      <= '0;
      whead      <= '0;
      rcount     <= '0;
      wcount     <= '0;
      k          <= '0;
      last_id    <= '0;
      last_prio  <= '0;
      last_valid <= 1'b0;
      cand_id    <= '0;
      cand_prio  <= '0;
      new_ticks  <= '0;
      res_found  <= 1'b0;
      res_id     <= '0;
      res_prio   <= '0;
      res_status <= ST_OK;
    end else begin
      case (cmd.uop)
        UOP_LOAD: begin
          cand_id    <= (operation == OP_RERUN) ? last_id : in_id;
          cand_prio  <= (operation == OP_RERUN) ? last_prio : priority_req;
          new_ticks  <= TICK_W'({1'b0, delay}) + TICK_W'(1);
          res_found  <= 1'b0;
          res_id     <= '0;
          res_prio   <= '0;
          res_status <= (operation == OP_RERUN && !last_valid) ? ST_NO_TASK : ST_OK;
        end
        UOP_RI_START: begin
          k <= rcount;
          if (stat.rfull) res_status <= ST_READY_FULL;
        end
        UOP_RI_SCAN: begin
          if (stat.r_shift) k <= k - CW'(1);
          else rcount <= rcount + CW'(1);
        end
        UOP_RI_PLACE: rcount <= rcount + CW'(1);
        UOP_WI_START: begin
          k <= wcount;
          if (stat.wfull) res_status <= ST_WAIT_FULL;
        end
        UOP_WI_SCAN: begin
          if (stat.w_shift) k <= k - CW'(1);
          else wcount <= wcount + CW'(1);
        end
        UOP_WI_PLACE: wcount <= wcount + CW'(1);
        UOP_DISP_TAKE: begin
          res_found  <= 1'b1;
          res_id     <= rrd_id;
          res_prio   <= rrd_prio;
          last_id    <= rrd_id;
          last_prio  <= rrd_prio;
          last_valid <= 1'b1;
          rhead      <= phys(rhead, CW'(1));
          rcount     <= rcount - CW'(1);
        end
        UOP_T_START: k <= '0;
        UOP_T_SWEEP: k <= k + CW'(1);
        UOP_CAND_WAIT: begin
          cand_id   <= wrd_id;
          cand_prio <= wrd_prio;
        end
        UOP_W_POP: begin
          whead  <= phys(whead, CW'(1));
          wcount <= wcount - CW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/priority_and_delay_task_queues_unit.sv @@
// ready/delay task queues: one word in at a time, one result word out per word
// enqueue and rerun scan from the tail, moving entries back to make room; dispatch reads the head,
// tick ages every waiting task in a sweep, then moves each expired head task into the ready queue;
// each queue memory does at most one read and one write per cycle
// a new word is taken while the previous result still waits in the output register
// synchronous active-high reset empties both queues and forgets the last dispatched task
module priority_and_delay_task_queues_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [7:0] task_id,
  input  logic [7:0] priority_req,
  input  logic [7:0] delay,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       found,
  output logic [7:0] out_task_id,
  output logic [7:0] out_priority,
  output logic [1:0] status,
  output logic [4:0] ready_entries,
  output logic [4:0] waiting_entries
);
  import pdtq_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  res_t  res;
  logic  busy;
  logic  out_free;

  assign in_stall = busy;
  assign out_free = !out_valid || !out_stall;

  pdtq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .delay     (delay),
    .out_free  (out_free),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  pdtq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .operation    (operation),
    .task_id      (task_id),
    .priority_req (priority_req),
    .delay        (delay),
    .stat         (stat),
    .res          (res)
  );

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      found           <= res.found;
      out_task_id     <= res.task_id;
      out_priority    <= res.prio;
      status          <= res.status;
      ready_entries   <= res.ready_entries;
      waiting_entries <= res.waiting_entries;
    end
  end

endmodule

@@ rtl/pdtq_checker.sv @@
// port-level checks of the ready/delay task queues, bound to the top level
// depends on assert_macros.svh and pdtq_pkg
`include "assert_macros.svh"

module pdtq_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       found,
  input logic [7:0] out_task_id,
  input logic [7:0] out_priority,
  input logic [1:0] status
);
  import pdtq_pkg::*;

  // a held result word keeps its task id and status
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_task_id) && $stable(status), "stalled result word changed")

  // one word in flight: input closes right after a word is taken
  `ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "word taken while previous still in work")

  // a dispatched task always reports ok
  `ASSERT_IMPLIES(a_found_ok, out_valid && found, status == ST_OK, "dispatched task with error status")

  // task fields stay clear when nothing was dispatched
  `ASSERT_IMPLIES(a_no_task_clean, out_valid && !found, out_task_id == 8'd0 && out_priority == 8'd0, "task fields set without a dispatch")

endmodule

bind priority_and_delay_task_queues_unit pdtq_checker u_pdtq_checker (.*);
